// File: sv/icl_pkg.sv
package icl_pkg;

  // Characters the lexer reacts to
  localparam logic [7:0] ChLbrack  = 8'h5B;
  localparam logic [7:0] ChRbrack  = 8'h5D;
  localparam logic [7:0] ChEqual   = 8'h3D;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChBslash  = 8'h5C;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChSzlig   = 8'hDF;
  localparam logic [7:0] ChUumlCap = 8'hDC;
  localparam logic [7:0] ChAumlSm  = 8'hE4;
  localparam logic [7:0] ChOumlSm  = 8'hF6;
  localparam logic [7:0] ChUumlSm  = 8'hFC;
  localparam logic [7:0] ChAumlCap = 8'hC4;
  localparam logic [7:0] ChOumlCap = 8'hD6;
  localparam logic [7:0] ChNl      = 8'h0A;
  localparam logic [7:0] ChSp      = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;

  localparam logic [15:0] LineMax = 16'hFFFF;

  typedef enum logic [3:0] {
    StSection    = 4'd0,
    StKey        = 4'd1,
    StValue      = 4'd2,
    StPrevalue   = 4'd3,
    StPresection = 4'd4,
    StLinestart  = 4'd5,
    StPreeol     = 4'd6,
    StComment    = 4'd7,
    StEscape     = 4'd8,
    StPrecomment = 4'd9
  } state_e;

  typedef enum logic [2:0] {
    EvNone     = 3'd0,
    EvSecChar  = 3'd1,
    EvKeyChar  = 3'd2,
    EvValChar  = 3'd3,
    EvSecEnd   = 3'd4,
    EvKeyEnd   = 3'd5,
    EvEntryEnd = 3'd6,
    EvError    = 3'd7
  } event_e;

  typedef enum logic [3:0] {
    ErrNone       = 4'd0,
    ErrNlSection  = 4'd1,
    ErrNlKey      = 4'd2,
    ErrNlValue    = 4'd3,
    ErrBadEscape  = 4'd4,
    ErrNoQuote    = 4'd5,
    ErrTrailing   = 4'd6,
    ErrNoSection  = 4'd7,
    ErrEofSection = 4'd8,
    ErrEofKey     = 4'd9,
    ErrEofValue   = 4'd10
  } err_e;

  // One classified byte as it travels through the queue
  typedef struct packed {
    logic       eof;
    logic [7:0] ch;
    logic       is_graph;
    logic       is_space;
    logic       is_name;
    logic       is_lbrack;
    logic       is_rbrack;
    logic       is_equal;
    logic       is_hash;
    logic       is_bslash;
    logic       is_quote;
    logic       is_nl;
    logic       is_sp;
  } item_t;

endpackage

// File: sv/ini_config_lexer.sv
// Byte-stream lexer for INI-style configuration text: [section] lines,
// key="value" lines, backslash escapes and # comments. Every accepted item
// (a file byte, or the end-of-file marker when func_i is set) yields exactly
// one result item: a name or value character, an end marker, a silent "none",
// or an error with its code and the line number it was found on. The lexer
// sustains one item per clock cycle while the output side is not stalled;
// the classified byte is written into the queue when its item is accepted,
// and the lexer state machine registers the result when it pops the item.
// The state machine in the back end sets that rate. A queue of QueueDepth
// entries sits between the classifier and the state machine, so input is
// still taken for a while when the output side stalls. After the first
// syntax error file bytes give "none" until the end marker, which always
// returns the lexer to its reset state for the next file.
module ini_config_lexer #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_res_o,
  output logic [7:0]  char_out_o,
  output logic        space_before_o,
  output logic [3:0]  error_code_o,
  output logic [15:0] line_number_o
);

  // Handshake between the classifier, the queue and the state machine
  logic           q_full, q_empty, q_push, q_pop;
  icl_pkg::item_t push_item, pop_item;

  // Front: accept the byte and tag it with its character classes
  icl_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .byte_in_i  (byte_in_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (push_item)
  );

  // Queue: hold classified items while the back end stalls
  icl_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_item_o  (pop_item)
  );

  // Back: advance the parser state and register one result per item
  icl_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_item_i       (pop_item),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_res_o    (event_res_o),
    .char_out_o     (char_out_o),
    .space_before_o (space_before_o),
    .error_code_o   (error_code_o),
    .line_number_o  (line_number_o)
  );

endmodule

// File: sv/icl_front.sv
module icl_front (
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            func_i,
  input  logic [7:0]      byte_in_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output icl_pkg::item_t  q_item_o
);

  logic graph;

  assign in_ready_o = ~q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;
  assign graph      = (byte_in_i >= 8'h21) && (byte_in_i <= 8'h7E);

  always_comb begin
    q_item_o.eof       = func_i;
    q_item_o.ch        = byte_in_i;
    q_item_o.is_graph  = graph;
    q_item_o.is_space  = (byte_in_i == icl_pkg::ChSp) ||
                         ((byte_in_i >= 8'h09) && (byte_in_i <= 8'h0D));
    q_item_o.is_name   = graph || (byte_in_i == icl_pkg::ChSp) ||
                         (byte_in_i == icl_pkg::ChTab) ||
                         (byte_in_i == icl_pkg::ChSzlig) ||
                         (byte_in_i == icl_pkg::ChAumlSm) ||
                         (byte_in_i == icl_pkg::ChOumlSm) ||
                         (byte_in_i == icl_pkg::ChUumlSm) ||
                         (byte_in_i == icl_pkg::ChAumlCap) ||
                         (byte_in_i == icl_pkg::ChOumlCap) ||
                         (byte_in_i == icl_pkg::ChUumlCap);
    q_item_o.is_lbrack = byte_in_i == icl_pkg::ChLbrack;
    q_item_o.is_rbrack = byte_in_i == icl_pkg::ChRbrack;
    q_item_o.is_equal  = byte_in_i == icl_pkg::ChEqual;
    q_item_o.is_hash   = byte_in_i == icl_pkg::ChHash;
    q_item_o.is_bslash = byte_in_i == icl_pkg::ChBslash;
    q_item_o.is_quote  = byte_in_i == icl_pkg::ChQuote;
    q_item_o.is_nl     = byte_in_i == icl_pkg::ChNl;
    q_item_o.is_sp     = byte_in_i == icl_pkg::ChSp;
  end

endmodule

// File: sv/icl_queue.sv
module icl_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  icl_pkg::item_t  push_item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output icl_pkg::item_t  pop_item_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  icl_pkg::item_t mem_q [Depth];
  logic [AW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;

  assign full_o     = cnt_q == CW'(Depth);
  assign empty_o    = cnt_q == '0;
  assign pop_item_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == AW'(Depth - 1)) ? '0 : rptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

endmodule

// File: sv/icl_back.sv
module icl_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  icl_pkg::item_t  q_item_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [2:0]      event_res_o,
  output logic [7:0]      char_out_o,
  output logic            space_before_o,
  output logic [3:0]      error_code_o,
  output logic [15:0]     line_number_o
);

  icl_pkg::state_e state_q, state_d;
  logic [15:0]     line_q, line_d;
  logic            spq_q, spq_d;
  logic            ns_q, ns_d;
  logic            halt_q, halt_d;

  icl_pkg::event_e ev;
  icl_pkg::err_e   err;
  logic [7:0]      ch;
  logic            sp;

  logic            ovalid_q;
  icl_pkg::event_e oev_q;
  icl_pkg::err_e   oerr_q;
  logic [7:0]      och_q;
  logic            osp_q;
  logic [15:0]     oline_q;

  icl_pkg::item_t  it;
  logic [15:0]     line_inc;

  assign it       = q_item_i;
  assign q_pop_o  = ~q_empty_i & (~ovalid_q | out_ready_i);
  assign line_inc = (line_q < icl_pkg::LineMax) ? line_q + 16'd1 : line_q;

  // Next state
  always_comb begin
    state_d = state_q;
    line_d  = line_q;
    spq_d   = spq_q;
    ns_d    = ns_q;
    halt_d  = halt_q;
    if (it.eof) begin
      state_d = icl_pkg::StPresection;
      line_d  = 16'd1;
      spq_d   = 1'b0;
      ns_d    = 1'b0;
      halt_d  = 1'b0;
    end else if (!halt_q) begin
      case (state_q)
        icl_pkg::StSection, icl_pkg::StKey: begin
          if ((state_q == icl_pkg::StSection) ? it.is_rbrack : it.is_equal) begin
            spq_d   = 1'b0;
            ns_d    = 1'b0;
            state_d = (state_q == icl_pkg::StSection) ? icl_pkg::StLinestart
                                                      : icl_pkg::StPrevalue;
          end else if (it.is_nl) begin
            halt_d = 1'b1;
          end else if (it.is_name) begin
            if (it.is_sp) begin
              if (ns_q) spq_d = 1'b1;
            end else begin
              ns_d  = 1'b1;
              spq_d = 1'b0;
            end
          end
        end
        icl_pkg::StValue: begin
          if (it.is_quote)       state_d = icl_pkg::StPreeol;
          else if (it.is_nl)     halt_d  = 1'b1;
          else if (it.is_bslash) state_d = icl_pkg::StEscape;
        end
        icl_pkg::StEscape: begin
          if (it.is_bslash || it.is_quote) state_d = icl_pkg::StValue;
          else                             halt_d  = 1'b1;
        end
        icl_pkg::StPrevalue: begin
          if (it.is_quote)       state_d = icl_pkg::StValue;
          else if (!it.is_space) halt_d  = 1'b1;
          else if (it.is_nl)     line_d  = line_inc;
        end
        icl_pkg::StPreeol: begin
          if (it.is_nl) begin
            state_d = icl_pkg::StLinestart;
            line_d  = line_inc;
          end else if (it.is_hash) begin
            state_d = icl_pkg::StComment;
          end else if (!it.is_space) begin
            halt_d = 1'b1;
          end
        end
        icl_pkg::StComment: begin
          if (it.is_nl) begin
            state_d = icl_pkg::StLinestart;
            line_d  = line_inc;
          end
        end
        icl_pkg::StPrecomment: begin
          if (it.is_nl) begin
            state_d = icl_pkg::StPresection;
            line_d  = line_inc;
          end
        end
        icl_pkg::StLinestart: begin
          if (it.is_lbrack) begin
            state_d = icl_pkg::StSection;
            spq_d   = 1'b0;
            ns_d    = 1'b0;
          end else if (it.is_hash) begin
            state_d = icl_pkg::StComment;
          end else if (it.is_graph) begin
            state_d = icl_pkg::StKey;
            spq_d   = 1'b0;
            ns_d    = 1'b1;
          end else if (it.is_nl) begin
            line_d = line_inc;
          end
        end
        default: begin
          if (it.is_lbrack) begin
            state_d = icl_pkg::StSection;
            spq_d   = 1'b0;
            ns_d    = 1'b0;
          end else if (it.is_hash) begin
            state_d = icl_pkg::StPrecomment;
          end else if (it.is_graph) begin
            halt_d = 1'b1;
          end else begin
            state_d = icl_pkg::StPresection;
            if (it.is_nl) line_d = line_inc;
          end
        end
      endcase
    end
  end

  // Result of the current item
  always_comb begin
    ev  = icl_pkg::EvNone;
    err = icl_pkg::ErrNone;
    ch  = 8'h00;
    sp  = 1'b0;
    if (it.eof) begin
      if (!halt_q) begin
        case (state_q)
          icl_pkg::StSection: err = icl_pkg::ErrEofSection;
          icl_pkg::StKey:     err = icl_pkg::ErrEofKey;
          icl_pkg::StValue,
          icl_pkg::StEscape:  err = icl_pkg::ErrEofValue;
          default:            err = icl_pkg::ErrNone;
        endcase
      end
      if (err != icl_pkg::ErrNone) ev = icl_pkg::EvError;
    end else if (!halt_q) begin
      case (state_q)
        icl_pkg::StSection, icl_pkg::StKey: begin
          if ((state_q == icl_pkg::StSection) ? it.is_rbrack : it.is_equal) begin
            ev = (state_q == icl_pkg::StSection) ? icl_pkg::EvSecEnd : icl_pkg::EvKeyEnd;
          end else if (it.is_nl) begin
            ev  = icl_pkg::EvError;
            err = (state_q == icl_pkg::StSection) ? icl_pkg::ErrNlSection
                                                  : icl_pkg::ErrNlKey;
          end else if (it.is_name && !it.is_sp) begin
            ev = (state_q == icl_pkg::StSection) ? icl_pkg::EvSecChar : icl_pkg::EvKeyChar;
            ch = it.ch;
            sp = spq_q & ns_q;
          end
        end
        icl_pkg::StValue: begin
          if (it.is_quote) begin
            ev = icl_pkg::EvEntryEnd;
          end else if (it.is_nl) begin
            ev  = icl_pkg::EvError;
            err = icl_pkg::ErrNlValue;
          end else if (!it.is_bslash && it.is_name) begin
            ev = icl_pkg::EvValChar;
            ch = it.ch;
          end
        end
        icl_pkg::StEscape: begin
          if (it.is_bslash || it.is_quote) begin
            ev = icl_pkg::EvValChar;
            ch = it.ch;
          end else begin
            ev  = icl_pkg::EvError;
            err = icl_pkg::ErrBadEscape;
          end
        end
        icl_pkg::StPrevalue: begin
          if (!it.is_quote && !it.is_space) begin
            ev  = icl_pkg::EvError;
            err = icl_pkg::ErrNoQuote;
          end
        end
        icl_pkg::StPreeol: begin
          if (!it.is_nl && !it.is_hash && !it.is_space) begin
            ev  = icl_pkg::EvError;
            err = icl_pkg::ErrTrailing;
          end
        end
        icl_pkg::StLinestart: begin
          if (!it.is_lbrack && !it.is_hash && it.is_graph) begin
            ev = icl_pkg::EvKeyChar;
            ch = it.ch;
          end
        end
        icl_pkg::StComment, icl_pkg::StPrecomment: begin
          ev = icl_pkg::EvNone;
        end
        default: begin
          if (!it.is_lbrack && !it.is_hash && it.is_graph) begin
            ev  = icl_pkg::EvError;
            err = icl_pkg::ErrNoSection;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= icl_pkg::StPresection;
      line_q   <= 16'd1;
      spq_q    <= 1'b0;
      ns_q     <= 1'b0;
      halt_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        state_q <= state_d;
        line_q  <= line_d;
        spq_q   <= spq_d;
        ns_q    <= ns_d;
        halt_q  <= halt_d;
      end
      if (q_pop_o)          ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      oev_q   <= ev;
      oerr_q  <= err;
      och_q   <= ch;
      osp_q   <= sp;
      oline_q <= line_q;
    end
  end

  assign out_valid_o    = ovalid_q;
  assign event_res_o    = oev_q;
  assign char_out_o     = och_q;
  assign space_before_o = osp_q;
  assign error_code_o   = oerr_q;
  assign line_number_o  = oline_q;

endmodule
